/* src/xkdmt_pkg.sv */
package xkdmt_pkg;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned BOARD_W = 64;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned FILL_W  = 13;
    localparam int unsigned INS_W   = 32;
    localparam int unsigned ADDR_W  = 6;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned REG_W   = 3;

    localparam logic [FILL_W-1:0] FILLED_MAX = {FILL_W{1'b1}};
    localparam logic [INS_W-1:0]  INSERT_MAX = {INS_W{1'b1}};

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    localparam logic [REG_W-1:0] REG_HASH_BLACK      = 3'd0;
    localparam logic [REG_W-1:0] REG_HASH_WHITE      = 3'd1;
    localparam logic [REG_W-1:0] REG_HASH_TURN_WHITE = 3'd2;
    localparam logic [REG_W-1:0] REG_HASH_TURN_BLACK = 3'd3;
    localparam logic [REG_W-1:0] REG_MISS_VALUE      = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [BOARD_W-1:0]        white;
        logic [BOARD_W-1:0]        black;
        logic                      side;
        logic signed [VALUE_W-1:0] value;
    } slot_t;

endpackage

/* src/xor_keyed_direct_mapped_table.sv */
// Direct-mapped position table keyed by an xor hash of two 64-bit boards and the
// side to move. The slot is the key's low log2(ENTRIES) bits.
// Request channel (s_*): valid/ready. req_type selects lookup or insert.
// Result channel (m_*): valid/ready, one result per request, in request order.
// Config: APB port, 64-bit registers at byte address 8*i (hash words, miss value);
// write only while no request is in flight.
// Path: an accepted request goes through the read stage to the output register.
// Throughput: one request per cycle unless m_* stalls; the slot memory is read
// at acceptance and written on leaving the read stage; a back-to-back request
// to the same slot takes the new entry from a forwarding register, not memory.
// Reset: counters and handshake state clear at once, then a clearing pass writes
// zero to every slot, one per cycle; s_ready stays low during the pass, config
// writes are taken as usual.
// Stall: while m_ready is low the result holds in the output register, one more
// request may sit in the read stage, and s_ready then drops until the result
// is taken.
module xor_keyed_direct_mapped_table #(
    parameter int unsigned ENTRIES = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [xkdmt_pkg::ADDR_W-1:0]        paddr,
    input  logic [xkdmt_pkg::DATA_W-1:0]        pwdata,
    output logic [xkdmt_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [xkdmt_pkg::BOARD_W-1:0]       s_white_board,
    input  logic [xkdmt_pkg::BOARD_W-1:0]       s_black_board,
    input  logic                                s_side_white,
    input  logic signed [xkdmt_pkg::VALUE_W-1:0] s_insert_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic signed [xkdmt_pkg::VALUE_W-1:0] m_read_value,
    output logic [xkdmt_pkg::FILL_W-1:0]        m_occupied_count,
    output logic [xkdmt_pkg::INS_W-1:0]         m_insert_count
);
    import xkdmt_pkg::*;

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // configuration
    logic [KEY_W-1:0]          hash_black_reg;
    logic [KEY_W-1:0]          hash_white_reg;
    logic [KEY_W-1:0]          hash_turn_white_reg;
    logic [KEY_W-1:0]          hash_turn_black_reg;
    logic signed [VALUE_W-1:0] miss_value_reg;

    logic             cfg_wr;
    logic [REG_W-1:0] cfg_idx;

    // slot memory
    slot_t            mem [ENTRIES];
    slot_t            rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;

    // clearing pass
    logic             clr_active_reg;
    logic [IDX_W-1:0] clr_cnt_reg;

    // read stage
    logic                      p1_valid_reg;
    logic                      p1_fwd_reg;
    logic                      p1_insert_reg;
    logic [KEY_W-1:0]          p1_key_reg;
    logic [BOARD_W-1:0]        p1_white_reg;
    logic [BOARD_W-1:0]        p1_black_reg;
    logic                      p1_side_reg;
    logic signed [VALUE_W-1:0] p1_value_reg;
    slot_t                     fwd_data_reg;

    logic [FILL_W-1:0] filled_reg;
    logic [FILL_W-1:0] filled_next;
    logic [INS_W-1:0]  inserts_reg;
    logic [INS_W-1:0]  inserts_next;

    logic                      m_valid_reg;
    logic                      m_hit_reg;
    logic signed [VALUE_W-1:0] m_read_value_reg;
    logic [FILL_W-1:0]         m_occupied_reg;
    logic [INS_W-1:0]          m_insert_reg;

    logic             acc_in;
    logic             out_free;
    logic             p1_done;
    logic             p1_write;
    logic [KEY_W-1:0] key_in;
    logic [IDX_W-1:0] idx_in;
    logic [IDX_W-1:0] p1_idx;
    slot_t            slot_cur;
    slot_t            slot_new;
    logic             match;

    // apb
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:ADDR_W-REG_W];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_black_reg      <= '0;
            hash_white_reg      <= '0;
            hash_turn_white_reg <= '0;
            hash_turn_black_reg <= '0;
            miss_value_reg      <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HASH_BLACK:      hash_black_reg      <= pwdata;
                REG_HASH_WHITE:      hash_white_reg      <= pwdata;
                REG_HASH_TURN_WHITE: hash_turn_white_reg <= pwdata;
                REG_HASH_TURN_BLACK: hash_turn_black_reg <= pwdata;
                REG_MISS_VALUE:      miss_value_reg      <= pwdata[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HASH_BLACK:      prdata = hash_black_reg;
            REG_HASH_WHITE:      prdata = hash_white_reg;
            REG_HASH_TURN_WHITE: prdata = hash_turn_white_reg;
            REG_HASH_TURN_BLACK: prdata = hash_turn_black_reg;
            REG_MISS_VALUE:      prdata = {{(DATA_W-VALUE_W){1'b0}}, miss_value_reg};
            default:             prdata = '0;
        endcase
    end

    // handshake
    assign out_free = ~m_valid_reg | m_ready;
    assign p1_done  = p1_valid_reg & out_free;
    assign p1_write = p1_done & (p1_insert_reg == REQ_INSERT);
    assign s_ready  = ~clr_active_reg & (~p1_valid_reg | out_free);
    assign acc_in   = s_valid & s_ready;

    assign key_in = (s_black_board ^ hash_black_reg) ^ (s_white_board ^ hash_white_reg)
                  ^ (s_side_white ? hash_turn_white_reg : hash_turn_black_reg);
    assign idx_in = key_in[IDX_W-1:0];
    assign p1_idx = p1_key_reg[IDX_W-1:0];

    // compare and update
    assign slot_cur = p1_fwd_reg ? fwd_data_reg : rd_data_reg;
    assign match    = (slot_cur.key == p1_key_reg) && (slot_cur.white == p1_white_reg)
                   && (slot_cur.black == p1_black_reg) && (slot_cur.side == p1_side_reg);

    always_comb begin
        slot_new.key   = p1_key_reg;
        slot_new.white = p1_white_reg;
        slot_new.black = p1_black_reg;
        slot_new.side  = p1_side_reg;
        slot_new.value = p1_value_reg;
    end

    always_comb begin
        filled_next  = filled_reg;
        inserts_next = inserts_reg;
        if (p1_write) begin
            if (slot_cur.key == '0 && filled_reg != FILLED_MAX) begin
                filled_next = filled_reg + 1'b1;
            end
            if (inserts_reg != INSERT_MAX) begin
                inserts_next = inserts_reg + 1'b1;
            end
        end
    end

    // memory write port shared by the clearing pass and inserts
    assign wr_en   = clr_active_reg | p1_write;
    assign wr_addr = clr_active_reg ? clr_cnt_reg : p1_idx;
    assign wr_data = clr_active_reg ? slot_t'('0) : slot_new;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (acc_in) begin
            rd_data_reg <= mem[idx_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end else if (clr_active_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_IDX) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_fwd_reg   <= 1'b0;
            filled_reg   <= '0;
            inserts_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            filled_reg  <= filled_next;
            inserts_reg <= inserts_next;
            if (acc_in) begin
                p1_valid_reg <= 1'b1;
                p1_fwd_reg   <= p1_write && (p1_idx == idx_in);
            end else if (p1_done) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_in) begin
            p1_insert_reg <= s_req_type;
            p1_key_reg    <= key_in;
            p1_white_reg  <= s_white_board;
            p1_black_reg  <= s_black_board;
            p1_side_reg   <= s_side_white;
            p1_value_reg  <= s_insert_value;
        end
        if (p1_write) begin
            fwd_data_reg <= slot_new;
        end
        if (p1_done) begin
            m_hit_reg        <= (p1_insert_reg == REQ_LOOKUP) && match;
            m_read_value_reg <= ((p1_insert_reg == REQ_LOOKUP) && match) ? slot_cur.value
                                                                         : miss_value_reg;
            m_occupied_reg   <= filled_next;
            m_insert_reg     <= inserts_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_hit            = m_hit_reg;
    assign m_read_value     = m_read_value_reg;
    assign m_occupied_count = m_occupied_reg;
    assign m_insert_count   = m_insert_reg;

endmodule

/* bench/tb_probe_pkg.sv */
`timescale 1ns / 1ps
package tb_probe_pkg;
    import xkdmt_pkg::*;

    localparam int unsigned SLOTS = 4096;
    localparam int unsigned IDX_W = 12;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] value;
        logic [FILL_W-1:0]         occupied;
        logic [INS_W-1:0]          inserts;
    } answer_t;

    class probe_book_t;
        logic [KEY_W-1:0]          hash_black;
        logic [KEY_W-1:0]          hash_white;
        logic [KEY_W-1:0]          hash_turn_white;
        logic [KEY_W-1:0]          hash_turn_black;
        logic signed [VALUE_W-1:0] miss_value;
        slot_t                     slots[SLOTS];
        logic [FILL_W-1:0]         filled;
        logic [INS_W-1:0]          inserted;
        answer_t                   awaited[$];
        int unsigned               requests;
        int unsigned               lookups;
        int unsigned               insert_reqs;
        int unsigned               hits;
        int unsigned               answers;
        int unsigned               errors;

        function new();
            foreach (slots[i]) slots[i] = '0;
            hash_black = '0;
            hash_white = '0;
            hash_turn_white = '0;
            hash_turn_black = '0;
            miss_value = '0;
            filled = '0;
            inserted = '0;
            requests = 0;
            lookups = 0;
            insert_reqs = 0;
            hits = 0;
            answers = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_HASH_BLACK: hash_black = data;
                REG_HASH_WHITE: hash_white = data;
                REG_HASH_TURN_WHITE: hash_turn_white = data;
                REG_HASH_TURN_BLACK: hash_turn_black = data;
                REG_MISS_VALUE: miss_value = data[VALUE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] read_reg(logic [REG_W-1:0] idx);
            case (idx)
                REG_HASH_BLACK: return hash_black;
                REG_HASH_WHITE: return hash_white;
                REG_HASH_TURN_WHITE: return hash_turn_white;
                REG_HASH_TURN_BLACK: return hash_turn_black;
                REG_MISS_VALUE: return {{(DATA_W-VALUE_W){1'b0}}, miss_value};
                default: return '0;
            endcase
        endfunction

        function logic [KEY_W-1:0] key_of(logic [BOARD_W-1:0] white,
                                          logic [BOARD_W-1:0] black, logic side);
            return black ^ hash_black ^ white ^ hash_white
                 ^ (side ? hash_turn_white : hash_turn_black);
        endfunction

        function void note_request(logic kind, logic [BOARD_W-1:0] white,
                                   logic [BOARD_W-1:0] black, logic side,
                                   logic signed [VALUE_W-1:0] value);
            logic [KEY_W-1:0] key;
            logic [IDX_W-1:0] idx;
            answer_t          ans;
            key = key_of(white, black, side);
            idx = key[IDX_W-1:0];
            ans.hit = 1'b0;
            ans.value = miss_value;
            requests++;
            if (kind == REQ_INSERT) begin
                insert_reqs++;
                // a stored key of zero counts as an empty slot
                if (slots[idx].key == '0 && filled != FILLED_MAX) filled++;
                if (inserted != INSERT_MAX) inserted++;
                slots[idx].key = key;
                slots[idx].white = white;
                slots[idx].black = black;
                slots[idx].side = side;
                slots[idx].value = value;
            end else begin
                lookups++;
                if (slots[idx].key == key && slots[idx].white == white &&
                    slots[idx].black == black && slots[idx].side == side) begin
                    ans.hit = 1'b1;
                    ans.value = slots[idx].value;
                    hits++;
                end
            end
            ans.occupied = filled;
            ans.inserts = inserted;
            awaited.push_back(ans);
        endfunction

        function void check_answer(answer_t got);
            answer_t want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: hit=%0b value=%0d occupied=%0d inserts=%0d",
                             got.hit, got.value, got.occupied, got.inserts);
                return;
            end
            want = awaited.pop_front();
            answers++;
            if (got.hit !== want.hit || got.value !== want.value ||
                got.occupied !== want.occupied || got.inserts !== want.inserts) begin
                errors++;
                if (errors <= 10) begin
                    $display("result %0d mismatch: expected hit=%0b value=%0d occupied=%0d",
                             answers - 1, want.hit, want.value, want.occupied);
                    $display("    expected inserts=%0d, got hit=%0b value=%0d",
                             want.inserts, got.hit, got.value);
                    $display("    got occupied=%0d inserts=%0d", got.occupied, got.inserts);
                end
            end
        endfunction
    endclass

endpackage

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import xkdmt_pkg::*;
    import tb_probe_pkg::*;

    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned PHASE_ITEMS = 350;
    localparam int unsigned FILL_BURST  = 40;
    localparam int unsigned POOL_MAX    = 64;
    localparam logic [REG_W-1:0] REG_SPARE = 3'd5;

    typedef struct packed {
        logic [BOARD_W-1:0] white;
        logic [BOARD_W-1:0] black;
        logic               side;
    } position_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_req_type;
    logic [BOARD_W-1:0]         s_white_board;
    logic [BOARD_W-1:0]         s_black_board;
    logic                       s_side_white;
    logic signed [VALUE_W-1:0]  s_insert_value;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_hit;
    logic signed [VALUE_W-1:0]  m_read_value;
    logic [FILL_W-1:0]          m_occupied_count;
    logic [INS_W-1:0]           m_insert_count;

    probe_book_t book;
    position_t   pool[$];
    int unsigned idle_pct = 0;
    bit          quiet = 1'b0;
    int unsigned long_hold_reqs = 0;
    int unsigned reg_writes = 0;
    int unsigned stall_cycles = 0;

    xor_keyed_direct_mapped_table #(.ENTRIES(SLOTS)) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_white_board    (s_white_board),
        .s_black_board    (s_black_board),
        .s_side_white     (s_side_white),
        .s_insert_value   (s_insert_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_read_value     (m_read_value),
        .m_occupied_count (m_occupied_count),
        .m_insert_count   (m_insert_count)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : result_side
        int unsigned hold;
        int unsigned served;
        answer_t     got;
        hold = 0;
        served = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.hit = m_hit;
                got.value = m_read_value;
                got.occupied = m_occupied_count;
                got.inserts = m_insert_count;
                book.check_answer(got);
            end
            if (served != long_hold_reqs) begin
                served = long_hold_reqs;
                hold = LONG_HOLD;
            end else if (hold == 0 && !quiet && $urandom_range(0, 99) < idle_pct) begin
                hold = $urandom_range(1, 18);
            end
            if (hold != 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic offer(input logic kind, input logic [BOARD_W-1:0] white,
                         input logic [BOARD_W-1:0] black, input logic side,
                         input logic signed [VALUE_W-1:0] value);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= kind;
        s_white_board <= white;
        s_black_board <= black;
        s_side_white <= side;
        s_insert_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        book.note_request(kind, white, black, side, value);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (book.awaited.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        book.write_reg(idx, data);
        reg_writes++;
        @(posedge aclk);
        if (prdata !== book.read_reg(idx)) begin
            book.errors++;
            if (book.errors <= 10)
                $display("register %0d read back %h, expected %h",
                         idx, prdata, book.read_reg(idx));
        end
    endtask

    task automatic set_regs(input logic [DATA_W-1:0] hb, input logic [DATA_W-1:0] hw,
                            input logic [DATA_W-1:0] htw, input logic [DATA_W-1:0] htb,
                            input logic [DATA_W-1:0] miss);
        write_reg(REG_HASH_BLACK, hb);
        write_reg(REG_HASH_WHITE, hw);
        write_reg(REG_HASH_TURN_WHITE, htw);
        write_reg(REG_HASH_TURN_BLACK, htb);
        write_reg(REG_MISS_VALUE, miss);
    endtask

    task automatic random_request();
        position_t        pos;
        logic [KEY_W-1:0] key;
        int unsigned      pick;
        int unsigned      bit_no;
        pick = $urandom_range(0, 99);
        pos.white = {$urandom, $urandom};
        pos.black = {$urandom, $urandom};
        pos.side = 1'($urandom_range(0, 1));
        if (pick < 35) begin
            if ($urandom_range(0, 1) == 1) begin
                // crowd a few slots so entries collide and evict
                key = {$urandom, $urandom};
                key[IDX_W-1:0] = IDX_W'($urandom_range(0, 31));
                pos.black = book.key_of(pos.white, key, pos.side);
            end
            pool.push_back(pos);
            if (pool.size() > POOL_MAX) pool.delete(0);
            offer(REQ_INSERT, pos.white, pos.black, pos.side, $urandom);
        end else if (pick < 70 && pool.size() != 0) begin
            pos = pool[$urandom_range(0, pool.size() - 1)];
            offer(REQ_LOOKUP, pos.white, pos.black, pos.side, $urandom);
        end else if (pick < 80 && pool.size() != 0) begin
            // same key and slot, boards differ
            pos = pool[$urandom_range(0, pool.size() - 1)];
            bit_no = $urandom_range(0, BOARD_W - 1);
            pos.white[bit_no] = ~pos.white[bit_no];
            pos.black[bit_no] = ~pos.black[bit_no];
            offer(REQ_LOOKUP, pos.white, pos.black, pos.side, $urandom);
        end else if (pick < 85 && pool.size() != 0) begin
            pos = pool[$urandom_range(0, pool.size() - 1)];
            offer(REQ_LOOKUP, pos.white, pos.black, ~pos.side, $urandom);
        end else if (pick < 90 && pool.size() != 0) begin
            pos = pool[$urandom_range(0, pool.size() - 1)];
            offer(REQ_INSERT, pos.white, pos.black, pos.side, $urandom);
        end else begin
            offer(1'($urandom_range(0, 1)), pos.white, pos.black, pos.side, $urandom);
        end
    endtask

    task automatic random_run(input int unsigned count);
        repeat (count) random_request();
    endtask

    task automatic zero_key_burst();
        position_t pos;
        repeat (FILL_BURST) begin
            pos.white = {$urandom, $urandom};
            pos.side = 1'($urandom_range(0, 1));
            pos.black = book.key_of(pos.white, '0, pos.side);
            offer(REQ_INSERT, pos.white, pos.black, pos.side, $urandom);
            if ($urandom_range(0, 15) == 0)
                offer(REQ_LOOKUP, pos.white, pos.black, pos.side, $urandom);
        end
    endtask

    initial begin : request_side
        logic [BOARD_W-1:0] pattern;
        book = new();
        pattern = 64'hA5A5_5A5A_0F0F_F0F0;
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_valid <= 1'b0;
        s_req_type <= REQ_LOOKUP;
        s_white_board <= '0;
        s_black_board <= '0;
        s_side_white <= 1'b0;
        s_insert_value <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // all hash words zero
        idle_pct = 20;
        offer(REQ_LOOKUP, '0, '0, 1'b0, 32'sd5);
        offer(REQ_LOOKUP, '1, '1, 1'b0, '0);
        offer(REQ_LOOKUP, '0, '0, 1'b1, '0);
        offer(REQ_INSERT, pattern, pattern, 1'b0, 32'h7fff_ffff);
        offer(REQ_INSERT, pattern, pattern, 1'b0, 32'h8000_0000);
        offer(REQ_LOOKUP, pattern, pattern, 1'b0, '0);
        offer(REQ_INSERT, '1, '0, 1'b1, '1);
        offer(REQ_LOOKUP, '1, '0, 1'b1, '0);
        offer(REQ_LOOKUP, '1, '0, 1'b0, '0);
        offer(REQ_INSERT, 64'h0fff, '0, 1'b0, 32'h7fff_ffff);
        offer(REQ_LOOKUP, '1, '0, 1'b1, '0);
        offer(REQ_LOOKUP, 64'h0fff, '0, 1'b0, '0);
        offer(REQ_INSERT, 64'h8000_0000_0000_0000, 64'h1, 1'b1, '0);
        offer(REQ_LOOKUP, 64'h8000_0000_0000_0000, 64'h1, 1'b1, '0);
        offer(REQ_LOOKUP, '0, '0, 1'b0, '0);
        drain();

        write_reg(REG_SPARE, {$urandom, $urandom});
        set_regs('1, '1, '1, '1, 64'h0000_0000_7fff_ffff);
        idle_pct = 0;
        random_run(PHASE_ITEMS);
        drain();

        set_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, 64'hffff_ffff_8000_0000);
        idle_pct = 25;
        long_hold_reqs++;
        random_run(PHASE_ITEMS);
        drain();

        set_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        idle_pct = 10;
        zero_key_burst();
        random_run(PHASE_ITEMS);
        drain();

        set_regs('0, '0, {$urandom, $urandom}, '0, '1);
        idle_pct = 15;
        random_run(PHASE_ITEMS / 2);
        quiet = 1'b1;
        random_run(PHASE_ITEMS / 2);
        drain();
        repeat (10) @(posedge aclk);

        if (book.awaited.size() != 0) begin
            $display("%0d results never arrived", book.awaited.size());
            book.errors++;
        end
        $display("covered %0d requests: %0d lookups (%0d hits), %0d inserts, %0d reg writes",
                 book.requests, book.lookups, book.hits, book.insert_reqs, reg_writes);
        $display("final occupied count %0d, insert count %0d, %0d mismatches",
                 book.filled, book.inserted, book.errors);
        if (book.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
